### rtl/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

### rtl/bmf_pkg.sv
`timescale 1ns / 1ps

package bmf_pkg;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int SUM_W     = 12;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_WIDTH      = 640;
    localparam int DEF_HEIGHT     = 480;

    // floor(x / 9) for x below 2304 as (x * ceil(2^16 / 9)) >> 16
    localparam logic [12:0] DIV9_MUL   = 13'd7282;
    localparam int          DIV9_SHIFT = 16;
    localparam int          PROD_W     = SUM_W + 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // position class of one item, known at accept time
    typedef struct packed {
        logic have;
        logic last;
        logic interior;
    } pos_info_t;

    function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(DIV9_MUL);
        return prod[DIV9_SHIFT +: CH_W];
    endfunction

endpackage

### rtl/bmf_ram.sv
`timescale 1ns / 1ps

module bmf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bmf_pos.sv
`timescale 1ns / 1ps

module bmf_pos
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         advance,
    output logic [$clog2(MAX_WIDTH)-1:0] col,
    output pos_info_t                    info
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int WIDTH_RST  = (DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_WIDTH;
    localparam int HEIGHT_RST = (DEF_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : DEF_HEIGHT;

    logic [WID_W-1:0] width_reg, width_next;
    logic [HGT_W-1:0] height_reg, height_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [WID_W-1:0] width_clamped;
    logic [HGT_W-1:0] height_clamped;
    logic             col_zero;
    logic             row_done;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            width_clamped  = WID_W'(1);
            height_clamped = HGT_W'(1);
        end
        else
        begin
            width_clamped  = (32'(cfg_data) > MAX_WIDTH) ? WID_W'(MAX_WIDTH)
                                                         : WID_W'(cfg_data);
            height_clamped = (32'(cfg_data) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT)
                                                          : HGT_W'(cfg_data);
        end
    end

    assign col_zero = (col_reg == '0);
    assign row_done = ((WID_W'(col_reg) + WID_W'(1)) == width_reg);

    always_comb
    begin
        info.have     = (!col_zero && row_reg != '0) ||
                        (col_zero && row_reg >= ROW_W'(2));
        // the last pixel of a frame leaves on the first item of row height + 1
        info.last     = col_zero && (row_reg > ROW_W'(height_reg));
        info.interior = (row_reg >= ROW_W'(2)) && (row_reg < ROW_W'(height_reg)) &&
                        (col_reg >= COL_W'(2));
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  width_next  = width_clamped;
                REG_FRAME_HEIGHT: height_next = height_clamped;
                default:          width_next  = width_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (advance)
        begin
            if (info.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_done)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_W'(WIDTH_RST);
            height_reg <= HGT_W'(HEIGHT_RST);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    assign col = col_reg;

endmodule

### rtl/bmf_window.sv
`timescale 1ns / 1ps

module bmf_window
    import bmf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  logic [PIX_W-1:0] top_pix,
    input  logic [PIX_W-1:0] mid_pix,
    input  logic [PIX_W-1:0] bot_pix,
    output logic [PIX_W-1:0] mean_pix,
    output logic [PIX_W-1:0] center_pix
);

    // index row*3+col, row 0 oldest line, col 2 newest column
    logic [PIX_W-1:0] win_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= top_pix;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= mid_pix;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= bot_pix;
        end
    end

    // the mean covers the window after this shift
    always_comb
    begin
        logic [SUM_W-1:0] s_top;
        logic [SUM_W-1:0] s_mid;
        logic [SUM_W-1:0] s_bot;
        for (int ch = 0; ch < 3; ch++)
        begin
            s_top = SUM_W'(win_reg[1][ch*CH_W +: CH_W]) +
                    SUM_W'(win_reg[2][ch*CH_W +: CH_W]) +
                    SUM_W'(top_pix[ch*CH_W +: CH_W]);
            s_mid = SUM_W'(win_reg[4][ch*CH_W +: CH_W]) +
                    SUM_W'(win_reg[5][ch*CH_W +: CH_W]) +
                    SUM_W'(mid_pix[ch*CH_W +: CH_W]);
            s_bot = SUM_W'(win_reg[7][ch*CH_W +: CH_W]) +
                    SUM_W'(win_reg[8][ch*CH_W +: CH_W]) +
                    SUM_W'(bot_pix[ch*CH_W +: CH_W]);
            mean_pix[ch*CH_W +: CH_W] = div9(s_top + s_mid + s_bot);
        end
    end

    assign center_pix = win_reg[5];

endmodule

### rtl/box_mean_filter_3x3_rgb.sv
`timescale 1ns / 1ps

// 3x3 box mean filter on a raster stream of 8-bit blue/green/red pixels.
// input beats carry one pixel each (in_valid / in_stall); a beat with flush
// set is a drain beat whose pixel fields are ignored. after the last pixel
// of a frame send frame_width + 1 flush beats; the last of them returns the
// frame's final pixel with end_of_frame set.
// output beats (out_valid / out_stall) carry the pixel frame_width + 1
// positions behind the input; interior pixels are the truncated 3x3 mean,
// border pixels pass unchanged. the first frame_width + 1 beats of a frame
// give no output beat.
// one beat per cycle sustained unless the receiver stalls; a beat is registered
// at accept with its line-buffer read, then window and mean fill the output register.
// the line buffers are one ram holding both previous rows per column.
// when the receiver stalls, the output register holds and in_stall rises
// only while the pipeline stage behind it is also full.
// reset clears the position counters and window, and loads 640 x 480
// (clamped to MAX_WIDTH / MAX_HEIGHT). write frame_width (index 0) or
// frame_height (index 1) only while idle; a write restarts the frame.

module box_mean_filter_3x3_rgb
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CH_W-1:0]      in_blue,
    input  logic [CH_W-1:0]      in_green,
    input  logic [CH_W-1:0]      in_red,
    input  logic                 flush,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CH_W-1:0]      out_blue,
    output logic [CH_W-1:0]      out_green,
    output logic [CH_W-1:0]      out_red,
    output logic                 end_of_frame
);

`include "assert_macros.svh"

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WORD_W = 2 * PIX_W;

    logic             accept;
    logic             s1_fire;
    logic [COL_W-1:0] pos_col;
    pos_info_t        pos_info;

    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    pos_info_t        s1_info_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             fwd_reg;
    logic [WORD_W-1:0] fwd_data_reg;

    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] line_word;
    logic [WORD_W-1:0] wr_word;
    logic [PIX_W-1:0]  mean_pix;
    logic [PIX_W-1:0]  center_pix;

    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_eof_reg;

    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign s1_fire  = s1_valid_reg && !(out_valid_reg && out_stall);

    bmf_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .col       (pos_col),
        .info      (pos_info)
    );

    // ram word: middle line in the upper half, upper line in the lower half
    bmf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (wr_word),
        .re    (accept),
        .raddr (pos_col),
        .rdata (ram_rdata)
    );

    // a one-pixel-wide frame rereads the column written in the same cycle
    assign line_word = fwd_reg ? fwd_data_reg : ram_rdata;
    assign wr_word   = {s1_pix_reg, line_word[WORD_W-1:PIX_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_fire && (s1_col_reg == pos_col);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= pos_col;
            s1_info_reg  <= pos_info;
            s1_pix_reg   <= flush ? '0 : {in_red, in_green, in_blue};
            fwd_data_reg <= wr_word;
        end
    end

    bmf_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (s1_fire),
        .top_pix    (line_word[PIX_W-1:0]),
        .mid_pix    (line_word[WORD_W-1:PIX_W]),
        .bot_pix    (s1_pix_reg),
        .mean_pix   (mean_pix),
        .center_pix (center_pix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= s1_info_reg.have;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_info_reg.have)
        begin
            out_pix_reg <= s1_info_reg.interior ? mean_pix : center_pix;
            out_eof_reg <= s1_info_reg.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_blue     = out_pix_reg[0*CH_W +: CH_W];
    assign out_green    = out_pix_reg[1*CH_W +: CH_W];
    assign out_red      = out_pix_reg[2*CH_W +: CH_W];
    assign end_of_frame = out_eof_reg;

    `ASSERT_NEVER(a_stall_needs_full, clk, rst_n,
        in_stall && !(out_valid_reg && out_stall && s1_valid_reg),
        "input stalled without a full pipeline")

    `ASSERT_CLK(a_frame_restart, clk, rst_n,
        (accept && pos_info.last) |=> (pos_col == '0),
        "position not restarted after frame end")

    `ASSERT_CLK(a_held_stage, clk, rst_n,
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_col_reg)),
        "stalled stage lost its beat")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bmf_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_MARK     = 250;
    localparam int RANDOM_ITEMS  = 400;
    localparam int PREFIX_ITEMS  = 24;
    localparam int UNLIMITED     = 1 << 30;

    typedef struct {
        bit               is_write;
        cfg_reg_t         wr_index;
        logic [CFG_W-1:0] wr_data;
        logic             fl;
        logic [CH_W-1:0]  b;
        logic [CH_W-1:0]  g;
        logic [CH_W-1:0]  r;
    } feed_t;

    typedef struct {
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] r;
        logic            eof;
    } pixel_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [CH_W-1:0]      in_blue;
    logic [CH_W-1:0]      in_green;
    logic [CH_W-1:0]      in_red;
    logic                 flush;
    logic                 out_valid;
    logic                 out_stall;
    logic [CH_W-1:0]      out_blue;
    logic [CH_W-1:0]      out_green;
    logic [CH_W-1:0]      out_red;
    logic                 end_of_frame;

    // stimulus and expected pixels
    feed_t  pixel_feed[$];
    pixel_t filtered_q[$];

    // filter state as the block should hold it
    logic [PIX_W-1:0] upper_row [DEF_MAX_WIDTH];
    logic [PIX_W-1:0] middle_row [DEF_MAX_WIDTH];
    logic [PIX_W-1:0] win [9];
    int col_pos;
    int row_pos;
    int frame_w;
    int frame_h;

    // frame size seen by the stimulus builder
    int fill_w;
    int fill_h;

    bit feed_taken  = 1'b0;
    bit out_taken   = 1'b0;
    bit long_hold   = 1'b0;
    bit feed_loaded = 1'b0;
    int tx_wait = 0;
    int tx_run  = 0;
    int rx_wait = 0;
    int rx_run  = 0;
    int quiet_cycles = 0;
    int cycle_count  = 0;
    int errors       = 0;

    box_mean_filter_3x3_rgb dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_blue      (in_blue),
        .in_green     (in_green),
        .in_red       (in_red),
        .flush        (flush),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_blue     (out_blue),
        .out_green    (out_green),
        .out_red      (out_red),
        .end_of_frame (end_of_frame)
    );

    always #2 clk = ~clk;

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] box_mean();
        logic [PIX_W-1:0] res;
        int sum;
        res = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = 0;
            for (int k = 0; k < 9; k++)
                sum += win[k][ch*CH_W +: CH_W];
            res[ch*CH_W +: CH_W] = CH_W'(sum / 9);
        end
        return res;
    endfunction

    function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
        if (idx == REG_FRAME_WIDTH)
            frame_w = clamp_dim(int'(val), DEF_MAX_WIDTH);
        else
            frame_h = clamp_dim(int'(val), DEF_MAX_HEIGHT);
        col_pos = 0;
        row_pos = 0;
    endfunction

    // one accepted beat: shift the window, update line buffers, maybe emit a pixel
    function automatic void filter_pixel(input logic fl, input logic [CH_W-1:0] blue,
                                         input logic [CH_W-1:0] green,
                                         input logic [CH_W-1:0] red);
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] prev_mid;
        logic [PIX_W-1:0] centre;
        logic [PIX_W-1:0] value;
        pixel_t res;
        int c;
        int rw;
        int idx;
        int rm;
        int cm;
        bit have;
        bit last;
        pix = fl ? '0 : {red, green, blue};
        c = col_pos;
        rw = row_pos;
        idx = (c < DEF_MAX_WIDTH) ? c : 0;
        prev_mid = win[5];
        win[0] = win[1];
        win[1] = win[2];
        win[3] = win[4];
        win[4] = win[5];
        win[6] = win[7];
        win[7] = win[8];
        win[2] = upper_row[idx];
        win[5] = middle_row[idx];
        win[8] = pix;
        upper_row[idx] = middle_row[idx];
        middle_row[idx] = pix;
        have = 1'b0;
        rm = 0;
        cm = 0;
        centre = '0;
        if (c >= 1 && rw >= 1)
        begin
            have = 1'b1;
            rm = rw - 1;
            cm = c - 1;
            centre = win[4];
        end
        else if (c == 0 && rw >= 2)
        begin
            // first column of a row closes the last pixel of the row two back
            have = 1'b1;
            rm = rw - 2;
            cm = frame_w - 1;
            centre = prev_mid;
        end
        c++;
        if (c >= frame_w)
        begin
            c = 0;
            rw++;
        end
        col_pos = c;
        row_pos = rw;
        if (have)
        begin
            last = (rm + 1 >= frame_h) && (cm + 1 >= frame_w);
            if (rm >= 1 && rm + 2 <= frame_h && cm >= 1 && cm + 2 <= frame_w)
                value = box_mean();
            else
                value = centre;
            if (last)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            res.b = value[7:0];
            res.g = value[15:8];
            res.r = value[23:16];
            res.eof = last;
            filtered_q.push_back(res);
        end
    endfunction

    function automatic int draw_wait(inout int run);
        if (run > 0)
        begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            run = $urandom_range(10, 50);
            return 0;
        end
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 18);
    endfunction

    function automatic logic [CH_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h",
                 cycle_count, what, got, want);
        errors++;
    endtask

    task automatic queue_beat(input logic fl, input logic [CH_W-1:0] b,
                              input logic [CH_W-1:0] g, input logic [CH_W-1:0] r);
        feed_t f;
        f.is_write = 1'b0;
        f.wr_index = REG_FRAME_WIDTH;
        f.wr_data = '0;
        f.fl = fl;
        f.b = b;
        f.g = g;
        f.r = r;
        pixel_feed.push_back(f);
    endtask

    task automatic queue_write(input cfg_reg_t idx, input int val);
        feed_t f;
        f.is_write = 1'b1;
        f.wr_index = idx;
        f.wr_data = CFG_W'(val);
        f.fl = 1'b0;
        f.b = '0;
        f.g = '0;
        f.r = '0;
        if (idx == REG_FRAME_WIDTH)
            fill_w = clamp_dim(val, DEF_MAX_WIDTH);
        else
            fill_h = clamp_dim(val, DEF_MAX_HEIGHT);
        pixel_feed.push_back(f);
    endtask

    // pixels of one frame then the drain beats, at most upto; noisy flips random beats between pixel and drain
    task automatic queue_frame(input bit noisy, input int upto);
        int total;
        logic fl;
        total = fill_w * fill_h + fill_w + 1;
        if (upto < total)
            total = upto;
        for (int k = 0; k < total; k++)
        begin
            fl = (k >= fill_w * fill_h);
            if (noisy && $urandom_range(0, 9) == 0)
                fl = ~fl;
            queue_beat(fl, pick_channel(), pick_channel(), pick_channel());
        end
    endtask

    // input side: offers beats, and register writes once everything has drained
    always @(negedge clk)
    begin : feed_drive
        logic next_valid;
        logic next_write;
        feed_t head;
        next_valid = in_valid;
        next_write = 1'b0;
        if (rst_n)
        begin
            if (feed_taken)
            begin
                feed_taken = 1'b0;
                next_valid = 1'b0;
                tx_wait = draw_wait(tx_run);
            end
            if (!next_valid)
            begin
                if (tx_wait > 0)
                    tx_wait--;
                else if (pixel_feed.size() > 0)
                begin
                    if (!pixel_feed[0].is_write)
                    begin
                        head = pixel_feed.pop_front();
                        in_blue <= head.b;
                        in_green <= head.g;
                        in_red <= head.r;
                        flush <= head.fl;
                        next_valid = 1'b1;
                    end
                    else if (quiet_cycles >= SETTLE_CYCLES && !cfg_write)
                    begin
                        head = pixel_feed.pop_front();
                        cfg_index <= head.wr_index;
                        cfg_data <= head.wr_data;
                        next_write = 1'b1;
                    end
                end
            end
        end
        in_valid <= next_valid;
        cfg_write <= next_write;
    end

    // output side: random stall per beat, plus the long hold
    always @(negedge clk)
    begin
        if (out_taken)
        begin
            out_taken = 1'b0;
            rx_wait = draw_wait(rx_run);
        end
        else if (rx_wait > 0)
            rx_wait--;
        out_stall <= (rx_wait > 0) || long_hold;
    end

    always @(posedge clk)
    begin : beat_watch
        pixel_t want;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[box_mean_filter_3x3_rgb] ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                filter_pixel(flush, in_blue, in_green, in_red);
                feed_taken = 1'b1;
            end
            if (cfg_write)
                load_register(cfg_index, cfg_data);
            if (out_valid && !out_stall)
            begin
                out_taken = 1'b1;
                if (filtered_q.size() == 0)
                    report_mismatch("beat with nothing pending", 32'(out_blue), 0);
                else
                begin
                    want = filtered_q.pop_front();
                    if (out_blue !== want.b)
                        report_mismatch("out_blue", 32'(out_blue), 32'(want.b));
                    if (out_green !== want.g)
                        report_mismatch("out_green", 32'(out_green), 32'(want.g));
                    if (out_red !== want.r)
                        report_mismatch("out_red", 32'(out_red), 32'(want.r));
                    if (end_of_frame !== want.eof)
                        report_mismatch("end_of_frame", 32'(end_of_frame), 32'(want.eof));
                end
            end
            if (filtered_q.size() == 0 && !in_valid && !out_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
        end
    end

    // hold the output off long enough for the block to back up into the input
    initial
    begin
        wait (feed_loaded);
        while (pixel_feed.size() > HOLD_MARK)
            @(posedge clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    initial
    begin : stimulus
        int w;
        int h;
        int n0;
        int kind;
        int random_count;
        bit first;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        in_blue = '0;
        in_green = '0;
        in_red = '0;
        flush = 1'b0;
        out_stall = 1'b0;

        for (int i = 0; i < DEF_MAX_WIDTH; i++)
        begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            win[i] = '0;
        col_pos = 0;
        row_pos = 0;
        frame_w = clamp_dim(DEF_WIDTH, DEF_MAX_WIDTH);
        frame_h = clamp_dim(DEF_HEIGHT, DEF_MAX_HEIGHT);
        fill_w = frame_w;
        fill_h = frame_h;

        // reset size: a short start of the first row, no pixel due yet
        queue_frame(1'b0, PREFIX_ITEMS);

        // 3x3: saturated frame, then a mixed one with a drain beat inside the
        // frame and a pixel where a drain beat is due
        queue_write(REG_FRAME_WIDTH, 3);
        queue_write(REG_FRAME_HEIGHT, 3);
        for (int i = 0; i < 9; i++)
            queue_beat(1'b0, '1, '1, '1);
        for (int i = 0; i < 4; i++)
            queue_beat(1'b1, pick_channel(), pick_channel(), pick_channel());
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4)
                queue_beat(1'b1, 8'h11, 8'h22, 8'h33);
            else
                queue_beat(1'b0, (i % 2) ? '1 : '0, (i % 2) ? '0 : '1, CH_W'(i * 31));
        end
        for (int i = 0; i < 4; i++)
            queue_beat(i != 1, 8'h5a, 8'ha5, 8'h3c);

        // zero clamps up to one, values past the maximum clamp down to it;
        // the large frames are only started, the next write restarts them
        queue_write(REG_FRAME_WIDTH, 0);
        queue_write(REG_FRAME_HEIGHT, 2047);
        queue_frame(1'b0, PREFIX_ITEMS);
        queue_write(REG_FRAME_WIDTH, 2047);
        queue_write(REG_FRAME_HEIGHT, 0);
        queue_frame(1'b0, PREFIX_ITEMS);

        random_count = 0;
        first = 1'b1;
        while (random_count < RANDOM_ITEMS)
        begin
            if (first || $urandom_range(0, 2) == 0)
            begin
                w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
                h = $urandom_range(1, 8);
                if (w == 1 && $urandom_range(0, 1))
                    w = 0;
                if (h == 1 && $urandom_range(0, 1))
                    h = 0;
                if (first || $urandom_range(0, 1))
                    queue_write(REG_FRAME_WIDTH, w);
                if (first || $urandom_range(0, 1))
                    queue_write(REG_FRAME_HEIGHT, h);
                first = 1'b0;
            end
            n0 = pixel_feed.size();
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // cut the frame short, a register write restarts it
                queue_frame(1'b1, $urandom_range(1, fill_w * fill_h + fill_w));
                random_count += pixel_feed.size() - n0;
                queue_write(REG_FRAME_HEIGHT, fill_h);
            end
            else
            begin
                queue_frame(kind == 1, UNLIMITED);
                random_count += pixel_feed.size() - n0;
            end
        end
        feed_loaded = 1'b1;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pixel_feed.size() != 0 || in_valid || filtered_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[box_mean_filter_3x3_rgb] OK");
        else
            $display("[box_mean_filter_3x3_rgb] ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_ram.sv
rtl/bmf_pos.sv
rtl/bmf_window.sv
rtl/box_mean_filter_3x3_rgb.sv
tb/testbench.sv
